// ----- sv/sha256_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared types, constants and round functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int BlockWords = 16;

    localparam logic [1:0] CFG_DIGEST_0 = 2'd0;
    localparam logic [1:0] CFG_DIGEST_1 = 2'd1;
    localparam logic [1:0] CFG_DIGEST_2 = 2'd2;
    localparam logic [1:0] CFG_DIGEST_3 = 2'd3;

    localparam logic [7:0] PAD_MARKER = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FINISH,
        ST_OUT
    } state_t;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ----- sv/sha256_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-wide streaming SHA-256 with digest output and compare against
// an expected digest.
// ----------------------------------------------------------------------------
// Input stalls: a byte that completes a block stalls input while the block is
//   loaded, run through the rounds and finished; other bytes do not stall.
//   A last item adds a padding sweep and one or two compressions, then 8 words.
// Throughput is set by the single shared round unit, one round per cycle.
// Reset: asynchronous, active low; chaining value, counters and expected
//   digest return to their initial values. Block store is not cleared.
module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // byte_present
    input  logic        s_tlast,   // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
    output logic        m_tuser,   // digest_matches
    output logic        m_tlast,   // last_word
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    // block memory: one write, one read per cycle, registered read
    logic [31:0] mem [BlockWords];
    logic        mem_we;
    logic [3:0]  mem_waddr;
    logic [31:0] mem_wdata;
    logic [3:0]  mem_raddr;
    logic [31:0] mem_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    state_t      state_reg, state_next;
    logic [31:0] hv_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] acc_reg, acc_next;
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] bits_reg, bits_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        final_reg, final_next;
    logic        second_reg, second_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic        match_reg, match_next;
    logic [63:0] exp_reg [4];

    logic        accept;
    logic [31:0] word_in;
    logic [31:0] t1, t2, wnew, wcur;
    logic [31:0] want;

    assign accept = s_tvalid && s_tready;

    // merge incoming byte into current word (cleared on first byte)
    always_comb
    begin
        word_in = (pos_reg[1:0] == 2'd0) ? 32'd0 : acc_reg;
        case (pos_reg[1:0])
            2'd0: word_in[31:24] = s_tdata;
            2'd1: word_in[23:16] = s_tdata;
            2'd2: word_in[15:8]  = s_tdata;
            default: word_in[7:0] = s_tdata;
        endcase
    end

    assign wcur = (cnt_reg < 7'd16) ? w_reg[cnt_reg[3:0]] : wnew;
    assign wnew = sig1(w_reg[14]) + w_reg[9] + sig0(w_reg[1]) + w_reg[0];
    assign t1 = v_reg[7] + bsig1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + ROUND_K[cnt_reg[5:0]] + wcur;
    assign t2 = bsig0(v_reg[0]) + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2])
              ^ (v_reg[1] & v_reg[2]));
    assign want = oidx_reg[0] ? exp_reg[oidx_reg[2:1]][31:0] : exp_reg[oidx_reg[2:1]][63:32];

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        pos_next    = pos_reg;
        bits_next   = bits_reg;
        cnt_next    = cnt_reg;
        final_next  = final_reg;
        second_next = second_reg;
        oidx_next   = oidx_reg;
        match_next  = match_reg;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg[5:2];
        mem_wdata   = word_in;
        mem_raddr   = cnt_reg[3:0];
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    if (s_tuser)
                    begin
                        acc_next  = word_in;
                        mem_we    = 1'b1;
                        pos_next  = pos_reg + 6'd1;
                        bits_next = bits_reg + 64'd8;
                    end
                    final_next  = s_tlast;
                    second_next = 1'b0;
                    if (s_tuser && pos_reg == 6'd63)
                    begin
                        state_next = ST_LOAD;
                        cnt_next   = 7'd0;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_PAD;
                        cnt_next   = {1'b0, (s_tuser ? pos_reg + 6'd1 : pos_reg)};
                    end
                end
            end
            ST_PAD:
            begin
                // cnt holds byte position; sweep words to end of block
                mem_waddr = cnt_reg[5:2];
                if (!second_reg)
                begin
                    mem_wdata = (cnt_reg[1:0] == 2'd0) ? 32'd0 : acc_reg;
                    case (cnt_reg[1:0])
                        2'd0: mem_wdata[31:24] = PAD_MARKER;
                        2'd1: mem_wdata[23:16] = PAD_MARKER;
                        2'd2: mem_wdata[15:8]  = PAD_MARKER;
                        default: mem_wdata[7:0] = PAD_MARKER;
                    endcase
                end
                else
                begin
                    mem_wdata = 32'd0;
                end
                // length goes into the block only when it fits after the marker
                if (cnt_reg[5:2] == 4'd14 && pos_reg < 6'd56)
                begin
                    mem_wdata = bits_reg[63:32];
                end
                if (cnt_reg[5:2] == 4'd15 && pos_reg < 6'd56)
                begin
                    mem_wdata = bits_reg[31:0];
                end
                mem_we      = 1'b1;
                second_next = 1'b1;
                if (cnt_reg[5:2] == 4'd15)
                begin
                    state_next = ST_LOAD;
                    cnt_next   = 7'd0;
                end
                else
                begin
                    cnt_next = {1'b0, cnt_reg[5:2] + 4'd1, 2'b00};
                end
            end
            ST_LOAD:
            begin
                // cnt 0..16: read words into schedule regs
                mem_raddr = cnt_reg[3:0];
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == 7'd16)
                begin
                    state_next = ST_ROUND;
                    cnt_next   = 7'd0;
                end
            end
            ST_ROUND:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!final_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!second_reg)
                begin
                    // padding still pending (block filled by last byte)
                    state_next = ST_PAD;
                    cnt_next   = 7'd0;
                end
                else if (pos_reg >= 6'd56 && pos_reg[5:0] != 6'd0 && cnt_reg == 7'd64)
                begin
                    // length block follows
                    state_next = ST_PAD;
                    cnt_next   = 7'd0;
                    pos_next   = 6'd0;
                end
                else
                begin
                    state_next = ST_OUT;
                    oidx_next  = 3'd0;
                    match_next = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    match_next = match_reg && (hv_reg[oidx_reg] == want);
                    oidx_next  = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                        pos_next   = 6'd0;
                        bits_next  = 64'd0;
                        final_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            bits_reg   <= '0;
            cnt_reg    <= '0;
            final_reg  <= 1'b0;
            second_reg <= 1'b0;
            oidx_reg   <= '0;
            match_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                hv_reg[i] <= H_INIT[i];
            end
            for (int i = 0; i < 4; i++)
            begin
                exp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            bits_reg   <= bits_next;
            cnt_reg    <= cnt_next;
            final_reg  <= final_next;
            second_reg <= second_next;
            oidx_reg   <= oidx_next;
            match_reg  <= match_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DIGEST_0: exp_reg[0] <= cfg_data;
                    CFG_DIGEST_1: exp_reg[1] <= cfg_data;
                    CFG_DIGEST_2: exp_reg[2] <= cfg_data;
                    CFG_DIGEST_3: exp_reg[3] <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_FINISH)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hv_reg[i] <= hv_reg[i] + v_reg[i];
                end
            end
            if (state_reg == ST_OUT && m_tready && oidx_reg == 3'd7)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hv_reg[i] <= H_INIT[i];
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (state_reg == ST_LOAD)
        begin
            if (cnt_reg != 7'd0)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i + 1];
                end
                w_reg[15] <= mem_rdata_reg;
            end
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= hv_reg[i];
            end
        end
        if (state_reg == ST_ROUND)
        begin
            // window holds W[t-16..t-1] from round 16 on
            if (cnt_reg >= 7'd16)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i + 1];
                end
                w_reg[15] <= wnew;
            end
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {5'd0, oidx_reg, hv_reg[oidx_reg]};
    assign m_tlast  = (oidx_reg == 3'd7);
    assign m_tuser  = (oidx_reg == 3'd7) && match_reg && (hv_reg[oidx_reg] == want);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken during digest output");
    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (cnt_reg < 7'd64))
        else $error("round counter overrun");
    a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && oidx_reg == $past(oidx_reg) + 3'd1))
        else $error("digest words out of order");

endmodule

// ----- tb/sv/sha256_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher checker
// Watches the input and output streams and the register port, computes the
// expected digest words for every finished message and compares them.
// ----------------------------------------------------------------------------
module sha256_checker
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          words_seen,
    output int          digests_seen
);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
        logic        match_flag;
    } digest_word_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [63:0]  exp_digest [4];
    logic [31:0]  hash_state [8];
    logic [31:0]  msg_block [16];
    logic [5:0]   fill_pos;
    logic [63:0]  msg_bits;
    digest_word_t digest_q [$];

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = msg_block[i];
        for (int i = 16; i < 64; i++)
            w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
               + K_TAB[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    task automatic place_byte(int pos, logic [7:0] b);
        if (pos % 4 == 0)
            msg_block[pos / 4] = '0;
        msg_block[pos / 4][(3 - pos % 4) * 8 +: 8] = b;
    endtask

    task automatic new_message();
        for (int i = 0; i < 8; i++)
            hash_state[i] = INIT_HASH[i];
        for (int i = 0; i < 16; i++)
            msg_block[i] = '0;
        fill_pos = '0;
        msg_bits = '0;
    endtask

    task automatic finish_message();
        logic         all_eq;
        logic [31:0]  want;
        digest_word_t dw;
        all_eq = 1'b1;
        place_byte(fill_pos, PAD_MARKER);
        for (int i = fill_pos + 1; i < 64; i++)
            place_byte(i, 8'h00);
        if (fill_pos >= 56)
        begin
            compress();
            for (int i = 0; i < 16; i++)
                msg_block[i] = '0;
        end
        msg_block[14] = msg_bits[63:32];
        msg_block[15] = msg_bits[31:0];
        compress();
        for (int i = 0; i < 8; i++)
        begin
            want = i[0] ? exp_digest[i / 2][31:0] : exp_digest[i / 2][63:32];
            if (hash_state[i] != want)
                all_eq = 1'b0;
            dw.word       = hash_state[i];
            dw.index      = i[2:0];
            dw.last       = (i == 7);
            dw.match_flag = (i == 7) && all_eq;
            digest_q.push_back(dw);
        end
        new_message();
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        digest_word_t exp_w;
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                exp_digest[i] = '0;
            new_message();
            digest_q.delete();
            fail_count   = 0;
            pending      = 0;
            words_seen   = 0;
            digests_seen = 0;
        end
        else
        begin
            if (cfg_we)
                exp_digest[cfg_index] = cfg_data;
            if (m_tvalid && m_tready)
            begin
                words_seen++;
                if (digest_q.size() == 0)
                    report("unexpected word", m_tdata[31:0], '0);
                else
                begin
                    exp_w = digest_q.pop_front();
                    if (m_tdata[31:0] != exp_w.word)
                        report("digest_word", m_tdata[31:0], exp_w.word);
                    if (m_tdata[34:32] != exp_w.index)
                        report("word_index", m_tdata[34:32], exp_w.index);
                    if (m_tdata[39:35] != '0)
                        report("pad bits", m_tdata[39:35], '0);
                    if (m_tlast != exp_w.last)
                        report("last_word", m_tlast, exp_w.last);
                    if (m_tuser != exp_w.match_flag)
                        report("digest_matches", m_tuser, exp_w.match_flag);
                    if (exp_w.last)
                        digests_seen++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser)
                begin
                    place_byte(fill_pos, s_tdata);
                    msg_bits += 64'd8;
                    fill_pos++;
                    if (fill_pos == 0)
                        compress();
                end
                if (s_tlast)
                    finish_message();
            end
            pending = digest_q.size();
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Streams directed and random messages through the hasher under several
// idling phases, rewrites the expected digest between messages and leaves
// all checking to the checker module.
// ----------------------------------------------------------------------------
module testbench;
    import sha256_pkg::*;

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles   = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_DIGEST_0;
    logic [63:0] cfg_data = '0;

    int fail_count, pending, words_seen, digests_seen;
    int send_idle_pct, recv_stall_pct;
    int idle_cycles;
    int bytes_sent;
    logic [31:0] last_digest [8];

    always #1 clk = ~clk;

    sha256_stream_hasher u_top (.*);

    sha256_checker u_chk (.*);

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready && !m_tlast)
            last_digest[m_tdata[34:32]] <= m_tdata[31:0];
        else if (m_tvalid && m_tready)
            last_digest[7] <= m_tdata[31:0];
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("watchdog expired");
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_word(logic [7:0] b, logic present, logic last);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= $urandom;
            s_tlast  <= $urandom;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= present;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (present)
            bytes_sent++;
    endtask

    task automatic send_message(int len, int noise_pct, bit last_alone);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                send_word($urandom, 1'b0, 1'b0);
            send_word($urandom, 1'b1, (i == len - 1) && !last_alone);
        end
        if (last_alone || len == 0)
            send_word($urandom, 1'b0, 1'b1);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic load_expected(bit use_last);
        for (int r = 0; r < 4; r++)
            write_reg(r[1:0], use_last ? {last_digest[2*r], last_digest[2*r+1]}
                                       : {$urandom, $urandom});
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        idle_cycles    = 0;
        bytes_sent     = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message twice (second one matches), extremes
        send_message(0, 0, 0);
        wait_idle();
        load_expected(1);
        send_message(0, 0, 0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b1);
        send_message(3, 0, 1);
        wait_idle();
        for (int r = 0; r < 4; r++)
            write_reg(r[1:0], 64'hffff_ffff_ffff_ffff);
        cfg_we <= 1'b0;
        // block boundaries: length spills into an extra block, last byte fills it
        send_message(56, 0, 0);
        send_message(64, 0, 0);
        wait_idle();
        for (int r = 0; r < 4; r++)
            write_reg(r[1:0], '0);
        cfg_we <= 1'b0;

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1 || phase == 3) ? (phase == 1 ? 74 : 20) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 74 : 20) : 0;
            for (int m = 0; m < 3; m++)
                send_message($urandom_range(10), 5, $urandom_range(1));
            wait_idle();
            load_expected($urandom_range(1));
        end

        wait_idle();
        $display("covered %0d message bytes, %0d digests, %0d digest words",
                 bytes_sent, digests_seen, words_seen);
        $display("four idling phases, digest match and mismatch, block boundaries");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
